>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked only while reset is released
`define ASSERT_RESET(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

>>> rtl/lrd_pkg.sv
// Shared types, constants and helpers of the DDA line rasteriser
package lrd_pkg;

  // Coordinate and fixed-point geometry
  localparam int unsigned CoordW   = 16;
  localparam int unsigned PosW     = CoordW + 1;
  localparam int unsigned FracBits = 8;
  localparam int unsigned AccW     = 32;
  localparam int unsigned QuotW    = CoordW + FracBits;
  localparam int unsigned DivCntW  = $clog2(QuotW);
  localparam logic [FracBits-1:0] HalfPixel = {1'b1, {(FracBits-1){1'b0}}};

  // Configuration register widths
  localparam int unsigned ScreenW  = 15;
  localparam int unsigned BppW     = 6;
  localparam int unsigned ColourW  = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ScreenW-1:0] ResetWidth  = ScreenW'(128);
  localparam logic [ScreenW-1:0] ResetHeight = ScreenW'(64);
  localparam logic [BppW-1:0]    ResetBpp    = BppW'(1);
  localparam logic [ColourW-1:0] ResetColour = '1;

  // Queue depths (powers of two, pointers wrap naturally)
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned OutDepth = 2;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BPP    = 2'd2,
    REG_COLOUR = 2'd3
  } reg_idx_e;

  typedef enum logic {
    BK_RUN,
    BK_DIVIDE
  } back_state_e;

  typedef struct packed {
    logic [ScreenW-1:0] width;
    logic [ScreenW-1:0] height;
    logic [BppW-1:0]    bpp;
    logic [ColourW-1:0] colour;
  } cfg_t;

  // Classified request handed from front end to back end
  typedef struct packed {
    op_e                      op;
    logic                     x_major;
    logic                     minor_neg;
    logic [CoordW-1:0]        minor_mag;
    logic [CoordW-1:0]        major_len;
    logic signed [CoordW-1:0] major_start;
    logic signed [CoordW-1:0] major_end;
    logic signed [CoordW-1:0] minor_start;
  } cmd_t;

  // Low-bit mask for the colour depth; 32 or more keeps all bits
  function automatic logic [ColourW-1:0] colour_mask(input logic [BppW-1:0] bpp);
    logic [ColourW-1:0] m;
    if (bpp >= BppW'(ColourW)) begin
      m = '1;
    end else begin
      m = (ColourW'(1) << bpp) - ColourW'(1);
    end
    return m;
  endfunction

endpackage

>>> rtl/lrd_cmd_fifo.sv
// Short request queue between the front end and the back end
module lrd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  lrd_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output lrd_pkg::cmd_t rd_data_o
);

  lrd_pkg::cmd_t                 mem_q [lrd_pkg::CmdDepth];
  logic [lrd_pkg::CmdPtrW-1:0]   wptr_q, rptr_q;
  logic [lrd_pkg::CmdPtrW:0]     cnt_q;
  logic                          wr_en, rd_en;

  assign wr_ready_o = (cnt_q != (lrd_pkg::CmdPtrW + 1)'(lrd_pkg::CmdDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_ready_i && rd_valid_o;
  assign rd_data_o  = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) wptr_q <= wptr_q + lrd_pkg::CmdPtrW'(1);
      if (rd_en) rptr_q <= rptr_q + lrd_pkg::CmdPtrW'(1);
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + (lrd_pkg::CmdPtrW + 1)'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - (lrd_pkg::CmdPtrW + 1)'(1);
      end
    end
  end

endmodule

>>> rtl/lrd_front.sv
// Front end: takes requests, works out deltas, major axis and endpoint order
module lrd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic                              operation_i,
  input  logic signed [lrd_pkg::CoordW-1:0] start_x_i,
  input  logic signed [lrd_pkg::CoordW-1:0] start_y_i,
  input  logic signed [lrd_pkg::CoordW-1:0] end_x_i,
  input  logic signed [lrd_pkg::CoordW-1:0] end_y_i,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i,
  output lrd_pkg::cmd_t                     cmd_o
);

  // stage A: captured request
  logic                              a_valid_q;
  lrd_pkg::op_e                      a_op_q;
  logic signed [lrd_pkg::CoordW-1:0] a_x1_q, a_y1_q, a_x2_q, a_y2_q;

  // stage B: raw deltas
  logic                              b_valid_q;
  lrd_pkg::op_e                      b_op_q;
  logic signed [lrd_pkg::CoordW-1:0] b_x1_q, b_y1_q, b_x2_q, b_y2_q;
  logic signed [lrd_pkg::PosW-1:0]   b_dxr_q, b_dyr_q;

  logic                              a_ready, b_ready;
  logic signed [lrd_pkg::PosW-1:0]   dxr, dyr;
  logic signed [lrd_pkg::PosW-1:0]   dx_abs, dy_abs;
  logic [lrd_pkg::CoordW-1:0]        dx_mag, dy_mag, dx_len, dy_len;
  logic                              x_major, swap;
  logic signed [lrd_pkg::CoordW-1:0] lo_x, lo_y, hi_x, hi_y;

  // elastic handshake through both stages
  assign b_ready     = !b_valid_q || cmd_ready_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign req_ready_o = a_ready;
  assign cmd_valid_o = b_valid_q;

  // signed differences, one bit wider than a coordinate
  assign dxr = lrd_pkg::PosW'(a_x2_q) - lrd_pkg::PosW'(a_x1_q);
  assign dyr = lrd_pkg::PosW'(a_y2_q) - lrd_pkg::PosW'(a_y1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= req_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && req_valid_i) begin
      a_op_q <= lrd_pkg::op_e'(operation_i);
      a_x1_q <= start_x_i;
      a_y1_q <= start_y_i;
      a_x2_q <= end_x_i;
      a_y2_q <= end_y_i;
    end
    if (b_ready && a_valid_q) begin
      b_op_q  <= a_op_q;
      b_x1_q  <= a_x1_q;
      b_y1_q  <= a_y1_q;
      b_x2_q  <= a_x2_q;
      b_y2_q  <= a_y2_q;
      b_dxr_q <= dxr;
      b_dyr_q <= dyr;
    end
  end

  // magnitudes; a zero length counts as one on the major axis
  assign dx_abs = b_dxr_q[lrd_pkg::PosW-1] ? -b_dxr_q : b_dxr_q;
  assign dy_abs = b_dyr_q[lrd_pkg::PosW-1] ? -b_dyr_q : b_dyr_q;
  assign dx_mag = dx_abs[lrd_pkg::CoordW-1:0];
  assign dy_mag = dy_abs[lrd_pkg::CoordW-1:0];
  assign dx_len = (dx_mag == '0) ? lrd_pkg::CoordW'(1) : dx_mag;
  assign dy_len = (dy_mag == '0) ? lrd_pkg::CoordW'(1) : dy_mag;

  // ties go to y; swap so the major coordinate ascends
  assign x_major = dx_len > dy_len;
  assign swap    = x_major ? b_dxr_q[lrd_pkg::PosW-1] : b_dyr_q[lrd_pkg::PosW-1];
  assign lo_x    = swap ? b_x2_q : b_x1_q;
  assign hi_x    = swap ? b_x1_q : b_x2_q;
  assign lo_y    = swap ? b_y2_q : b_y1_q;
  assign hi_y    = swap ? b_y1_q : b_y2_q;

  always_comb begin
    cmd_o.op          = b_op_q;
    cmd_o.x_major     = x_major;
    cmd_o.major_len   = x_major ? dx_len : dy_len;
    cmd_o.minor_mag   = x_major ? dy_mag : dx_mag;
    cmd_o.minor_neg   = (x_major ? b_dyr_q[lrd_pkg::PosW-1] : b_dxr_q[lrd_pkg::PosW-1]) ^ swap;
    cmd_o.major_start = x_major ? lo_x : lo_y;
    cmd_o.major_end   = x_major ? hi_x : hi_y;
    cmd_o.minor_start = x_major ? lo_y : lo_x;
  end

endmodule

>>> rtl/lrd_back.sv
// Back end: slope divider, DDA stepper, clipping and result queue
module lrd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lrd_pkg::cfg_t                      cfg_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  lrd_pkg::cmd_t                      cmd_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic signed [lrd_pkg::CoordW-1:0]  pixel_x_o,
  output logic signed [lrd_pkg::CoordW-1:0]  pixel_y_o,
  output logic [lrd_pkg::ColourW-1:0]        pixel_colour_o,
  output logic                               on_screen_o,
  output logic                               last_pixel_o
);

  typedef struct packed {
    logic signed [lrd_pkg::CoordW-1:0] x;
    logic signed [lrd_pkg::CoordW-1:0] y;
    logic [lrd_pkg::ColourW-1:0]       colour;
    logic                              on_screen;
    logic                              last;
  } pix_t;

  lrd_pkg::back_state_e state_q, state_d;
  logic                 drawing_q, drawing_d;

  // line state
  logic                              x_major_q, x_major_d;
  logic signed [lrd_pkg::PosW-1:0]   pos_q, pos_d;
  logic signed [lrd_pkg::CoordW-1:0] end_q, end_d;
  logic [lrd_pkg::AccW-1:0]          acc_q, acc_d;
  logic [lrd_pkg::AccW-1:0]          step_q, step_d;

  // restoring divider
  logic [lrd_pkg::CoordW-1:0]  rem_q, rem_d;
  logic [lrd_pkg::QuotW-1:0]   quo_q, quo_d;
  logic [lrd_pkg::CoordW-1:0]  den_q, den_d;
  logic                        neg_q, neg_d;
  logic [lrd_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [lrd_pkg::CoordW:0]    rem_shift, rem_sub;
  logic                        rem_ge;
  logic [lrd_pkg::CoordW-1:0]  rem_next;
  logic [lrd_pkg::QuotW-1:0]   quo_next;
  logic [lrd_pkg::AccW-1:0]    quo_ext;

  // pixel of the current step
  logic [lrd_pkg::CoordW-1:0] minor_c, major_c;
  pix_t                       pix;

  // result queue
  pix_t                        oq_q [lrd_pkg::OutDepth];
  logic [lrd_pkg::OutPtrW-1:0] oq_wptr_q, oq_rptr_q;
  logic [lrd_pkg::OutPtrW:0]   oq_cnt_q;
  logic                        oq_push, oq_pop, oq_space;
  pix_t                        oq_head;

  // one quotient bit per cycle
  assign rem_shift = {rem_q, quo_q[lrd_pkg::QuotW-1]};
  assign rem_ge    = rem_shift >= {1'b0, den_q};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign rem_next  = rem_ge ? rem_sub[lrd_pkg::CoordW-1:0] : rem_shift[lrd_pkg::CoordW-1:0];
  assign quo_next  = {quo_q[lrd_pkg::QuotW-2:0], rem_ge};
  assign quo_ext   = {{(lrd_pkg::AccW - lrd_pkg::QuotW){1'b0}}, quo_next};

  // pixel fields: minor is the accumulator's integer part kept to 16 bits
  assign minor_c = acc_q[lrd_pkg::FracBits +: lrd_pkg::CoordW];
  assign major_c = pos_q[lrd_pkg::CoordW-1:0];

  always_comb begin
    pix.x         = x_major_q ? major_c : minor_c;
    pix.y         = x_major_q ? minor_c : major_c;
    pix.colour    = cfg_i.colour & lrd_pkg::colour_mask(cfg_i.bpp);
    pix.last      = (pos_q == lrd_pkg::PosW'(end_q));
    pix.on_screen = !pix.x[lrd_pkg::CoordW-1] && !pix.y[lrd_pkg::CoordW-1] &&
                    (pix.x[lrd_pkg::ScreenW-1:0] < cfg_i.width) &&
                    (pix.y[lrd_pkg::ScreenW-1:0] < cfg_i.height);
  end

  assign oq_space = (oq_cnt_q != (lrd_pkg::OutPtrW + 1)'(lrd_pkg::OutDepth));

  // sequencer: next state, datapath loads and request handshake
  always_comb begin
    state_d     = state_q;
    drawing_d   = drawing_q;
    x_major_d   = x_major_q;
    pos_d       = pos_q;
    end_d       = end_q;
    acc_d       = acc_q;
    step_d      = step_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    cmd_ready_o = 1'b0;
    oq_push     = 1'b0;
    unique case (state_q)
      lrd_pkg::BK_RUN: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == lrd_pkg::OP_START) begin
            // new line replaces any line in progress
            cmd_ready_o = 1'b1;
            drawing_d   = 1'b0;
            x_major_d   = cmd_i.x_major;
            pos_d       = lrd_pkg::PosW'(cmd_i.major_start);
            end_d       = cmd_i.major_end;
            acc_d       = {{(lrd_pkg::AccW - lrd_pkg::QuotW){cmd_i.minor_start[lrd_pkg::CoordW-1]}},
                           cmd_i.minor_start, lrd_pkg::HalfPixel};
            rem_d       = '0;
            quo_d       = {cmd_i.minor_mag, {lrd_pkg::FracBits{1'b0}}};
            den_d       = cmd_i.major_len;
            neg_d       = cmd_i.minor_neg;
            cnt_d       = '0;
            state_d     = lrd_pkg::BK_DIVIDE;
          end else if (!drawing_q) begin
            // tick with no line: dropped
            cmd_ready_o = 1'b1;
          end else if (oq_space) begin
            cmd_ready_o = 1'b1;
            oq_push     = 1'b1;
            acc_d       = acc_q + step_q;
            pos_d       = pos_q + lrd_pkg::PosW'(1);
            if (pix.last) drawing_d = 1'b0;
          end
        end
      end
      lrd_pkg::BK_DIVIDE: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + lrd_pkg::DivCntW'(1);
        if (cnt_q == lrd_pkg::DivCntW'(lrd_pkg::QuotW - 1)) begin
          // quotient truncates toward zero, sign applied afterwards
          step_d    = neg_q ? -quo_ext : quo_ext;
          drawing_d = 1'b1;
          state_d   = lrd_pkg::BK_RUN;
        end
      end
      default: begin
        state_d = lrd_pkg::BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrd_pkg::BK_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drawing_q <= 1'b0;
    end else begin
      drawing_q <= drawing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_major_q <= x_major_d;
    pos_q     <= pos_d;
    end_q     <= end_d;
    acc_q     <= acc_d;
    step_q    <= step_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    cnt_q     <= cnt_d;
  end

  // result queue: the stepper keeps going while a result waits
  assign empty_o = (oq_cnt_q == '0);
  assign oq_pop  = pop_i && !empty_o;
  assign oq_head = oq_q[oq_rptr_q];

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wptr_q] <= pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wptr_q <= '0;
      oq_rptr_q <= '0;
      oq_cnt_q  <= '0;
    end else begin
      if (oq_push) oq_wptr_q <= oq_wptr_q + lrd_pkg::OutPtrW'(1);
      if (oq_pop)  oq_rptr_q <= oq_rptr_q + lrd_pkg::OutPtrW'(1);
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + (lrd_pkg::OutPtrW + 1)'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - (lrd_pkg::OutPtrW + 1)'(1);
      end
    end
  end

  assign pixel_x_o      = oq_head.x;
  assign pixel_y_o      = oq_head.y;
  assign pixel_colour_o = oq_head.colour;
  assign on_screen_o    = oq_head.on_screen;
  assign last_pixel_o   = oq_head.last;

endmodule

>>> rtl/line_rasterizer_dda_clipped.sv
// Top level of the clipped fixed-point DDA line rasteriser
//
// Requests enter through a queue-style port (push/full) and pixels leave
// through another (empty/pop). A start request latches two endpoints and
// yields no pixel; each tick request yields the next pixel of the line, and
// ticks with no line in progress are dropped. A start occupies the back end
// for a load and 24 steps of the restoring divider that produces the slope,
// one quotient bit per cycle. Ticks then run at one pixel per cycle while
// the two-entry result queue has room, one DDA step per pixel. A request
// passes from the front-end stage that accepts it through the second
// front-end stage, the four-entry request queue and the result queue, each
// registered, to the result port, and the request queue lets ticks be
// taken while a slope division runs.
// Configuration registers (index 0 width, 1 height, 2 colour depth,
// 3 foreground colour) are written on cfg_valid_i and are always ready.
module line_rasterizer_dda_clipped (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic                               operation_i,
  input  logic signed [lrd_pkg::CoordW-1:0]  start_x_i,
  input  logic signed [lrd_pkg::CoordW-1:0]  start_y_i,
  input  logic signed [lrd_pkg::CoordW-1:0]  end_x_i,
  input  logic signed [lrd_pkg::CoordW-1:0]  end_y_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [lrd_pkg::CoordW-1:0]  pixel_x_o,
  output logic signed [lrd_pkg::CoordW-1:0]  pixel_y_o,
  output logic [lrd_pkg::ColourW-1:0]        pixel_colour_o,
  output logic                               on_screen_o,
  output logic                               last_pixel_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lrd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lrd_pkg::ColourW-1:0]        cfg_data_i
);

  lrd_pkg::cfg_t cfg_q;
  logic          req_ready;
  logic          f_valid, f_ready, b_valid, b_ready;
  lrd_pkg::cmd_t f_cmd, b_cmd;

  assign full        = !req_ready;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= lrd_pkg::ResetWidth;
      cfg_q.height <= lrd_pkg::ResetHeight;
      cfg_q.bpp    <= lrd_pkg::ResetBpp;
      cfg_q.colour <= lrd_pkg::ResetColour;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lrd_pkg::reg_idx_e'(cfg_index_i))
        lrd_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data_i[lrd_pkg::ScreenW-1:0];
        lrd_pkg::REG_HEIGHT: cfg_q.height <= cfg_data_i[lrd_pkg::ScreenW-1:0];
        lrd_pkg::REG_BPP:    cfg_q.bpp    <= cfg_data_i[lrd_pkg::BppW-1:0];
        lrd_pkg::REG_COLOUR: cfg_q.colour <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (push),
    .req_ready_o (req_ready),
    .operation_i (operation_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  lrd_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_cmd)
  );

  lrd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (b_valid),
    .cmd_ready_o    (b_ready),
    .cmd_i          (b_cmd),
    .empty_o        (empty),
    .pop_i          (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour_o),
    .on_screen_o    (on_screen_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

>>> rtl/lrd_checker.sv
// Port-level checker for the line rasteriser, bound to the top level
`include "assert_macros.svh"

module lrd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [lrd_pkg::CoordW-1:0] pixel_x_o,
  input logic signed [lrd_pkg::CoordW-1:0] pixel_y_o,
  input logic                              on_screen_o,
  input logic                              last_pixel_o
);

  // reset leaves no result and room for a request
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result shown during reset")
  `ASSERT_ALWAYS(a_reset_not_full, !rst_ni |-> !full, "input full during reset")

  // a waiting result is held until taken
  `ASSERT_RESET(a_result_held, !empty && !pop |=> !empty && $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(last_pixel_o), "waiting result changed")

  // a visible pixel never has a negative coordinate
  `ASSERT_RESET(a_visible_nonneg, !empty && on_screen_o |-> !pixel_x_o[lrd_pkg::CoordW-1] && !pixel_y_o[lrd_pkg::CoordW-1], "visible pixel off screen")

endmodule

bind line_rasterizer_dda_clipped lrd_checker u_lrd_checker (.*);
